@@ rtl/bps_pkg.sv @@
package bps_pkg;

    // Widths of the ROM that holds the patterns.
    localparam int ROM_ROWS   = 16;
    localparam int ROM_COLS   = 16;
    localparam int ROM_ROW_W  = 4;
    localparam int ROM_COL_W  = 5;
    localparam int ENTRY_W    = 16;

    // Defaults for the top-level parameters.
    localparam int DEF_PATTERN_COUNT = 12;
    localparam int DEF_MAX_DURATION  = 1000;
    localparam int DEF_MAX_ENTRIES   = 7;

    // Number of zero-delay transitions one step may take before everything stops.
    localparam int RESOLVE_LIMIT = 4;

    // Marks that close a pattern.
    localparam logic signed [ENTRY_W-1:0] MARK_END    = 16'sd0;
    localparam logic signed [ENTRY_W-1:0] MARK_REPEAT = -16'sd1;

    // Operation codes of an input beat.
    typedef enum logic {
        OP_TICK  = 1'b0,
        OP_START = 1'b1
    } t_op;

    typedef struct packed {
        t_op        operation;
        logic [3:0] pattern;
    } t_in_item;

    typedef struct packed {
        logic buzzer_on;
        logic foreground_busy;
        logic background_busy;
        logic bad_pattern;
    } t_out_item;

    typedef logic signed [ENTRY_W-1:0] t_rom_row [ROM_COLS];

    localparam t_rom_row PATTERN_ROM [ROM_ROWS] = '{
        '{default: 16'sd0},
        '{0: 16'sd5, default: 16'sd0},
        '{0: 16'sd100, default: 16'sd0},
        '{0: 16'sd500, default: 16'sd0},
        '{0: 16'sd1000, default: 16'sd0},
        '{0: 16'sd80, 1: 16'sd160, 2: 16'sd80, 3: 16'sd680, default: 16'sd0},
        '{0: 16'sd80, 1: 16'sd160, 2: 16'sd80, 3: 16'sd680, 4: -16'sd1,
          default: 16'sd0},
        '{0: 16'sd80, 1: 16'sd50, 2: 16'sd80, 3: 16'sd50, 4: 16'sd80, 5: 16'sd600,
          6: -16'sd1, default: 16'sd0},
        '{0: 16'sd500, 1: 16'sd160, 2: 16'sd80, 3: 16'sd160, 4: 16'sd80,
          default: 16'sd0},
        '{0: 16'sd80, 1: 16'sd50, 2: 16'sd80, 3: 16'sd50, 4: 16'sd80,
          default: 16'sd0},
        '{0: 16'sd80, 1: 16'sd50, 2: 16'sd80, default: 16'sd0},
        '{0: 16'sd150, 1: 16'sd50, 2: 16'sd80, default: 16'sd0},
        '{default: 16'sd0},
        '{default: 16'sd0},
        '{default: 16'sd0},
        '{default: 16'sd0}
    };

    // An entry past the usable part of a pattern reads as an end mark.
    function automatic logic signed [ENTRY_W-1:0] rom_entry(
        input logic [ROM_ROW_W-1:0] pat,
        input logic [ROM_COL_W-1:0] idx,
        input int                   max_entries
    );
        logic signed [ENTRY_W-1:0] e;
        if (int'(idx) >= max_entries || int'(idx) >= ROM_COLS) begin
            e = MARK_END;
        end else begin
            e = PATTERN_ROM[pat][idx[ROM_COL_W-2:0]];
        end
        return e;
    endfunction

endpackage

@@ rtl/bps_step.sv @@
module bps_step #(
    parameter int PATTERN_COUNT = bps_pkg::DEF_PATTERN_COUNT,
    parameter int MAX_DURATION  = bps_pkg::DEF_MAX_DURATION,
    parameter int MAX_ENTRIES   = bps_pkg::DEF_MAX_ENTRIES,
    parameter int IW            = $clog2(MAX_ENTRIES + 1),
    parameter int RW            = $clog2(MAX_DURATION + 1)
) (
    input  bps_pkg::t_in_item  i_item,
    input  logic               i_front_active,
    input  logic [3:0]         i_front_pattern,
    input  logic [IW-1:0]      i_front_index,
    input  logic               i_back_active,
    input  logic [3:0]         i_back_pattern,
    input  logic [IW-1:0]      i_back_index,
    input  logic [RW-1:0]      i_remaining,
    input  logic               i_drive,
    output logic               o_front_active,
    output logic [3:0]         o_front_pattern,
    output logic [IW-1:0]      o_front_index,
    output logic               o_back_active,
    output logic [3:0]         o_back_pattern,
    output logic [IW-1:0]      o_back_index,
    output logic [RW-1:0]      o_remaining,
    output logic               o_drive,
    output bps_pkg::t_out_item o_result
);
    import bps_pkg::*;

    always_comb begin
        logic                      fa;
        logic [3:0]                fp;
        logic [IW-1:0]             fi;
        logic                      ba;
        logic [3:0]                bp;
        logic [IW-1:0]             bi;
        logic [RW-1:0]             rem;
        logic                      drv;
        logic                      bad;
        logic                      do_resolve;
        logic                      done;
        logic signed [ENTRY_W-1:0] e;

        fa  = i_front_active;
        fp  = i_front_pattern;
        fi  = i_front_index;
        ba  = i_back_active;
        bp  = i_back_pattern;
        bi  = i_back_index;
        rem = i_remaining;
        drv = i_drive;
        bad = 1'b0;
        do_resolve = 1'b0;
        done = 1'b0;
        e = MARK_END;

        if (i_item.operation == OP_START) begin
            if (int'(i_item.pattern) >= PATTERN_COUNT) begin
                bad = 1'b1;
            end
            if (bad || rom_entry(i_item.pattern, '0, MAX_ENTRIES) == MARK_END) begin
                fa  = 1'b0;
                ba  = 1'b0;
                rem = '0;
                drv = 1'b0;
            end else begin
                fa  = 1'b1;
                fp  = i_item.pattern;
                fi  = '0;
                rem = '0;
                do_resolve = 1'b1;
            end
        end else if (rem != '0) begin
            rem = rem - 1'b1;
            do_resolve = (rem == '0);
        end

        // Walk through end marks, repeat marks and the handover to the
        // background until a duration is loaded or nothing is left.
        if (do_resolve) begin
            for (int n = 0; n < RESOLVE_LIMIT; n++) begin
                if (!done) begin
                    if (fa) begin
                        e = rom_entry(fp, ROM_COL_W'(fi), MAX_ENTRIES);
                        if (e == MARK_END || e < MARK_REPEAT) begin
                            fa  = 1'b0;
                            drv = 1'b0;
                        end else if (e == MARK_REPEAT) begin
                            drv = 1'b0;
                            ba  = 1'b1;
                            bp  = fp;
                            bi  = '0;
                            fa  = 1'b0;
                        end else begin
                            rem  = (int'(e) > MAX_DURATION) ? RW'(MAX_DURATION) : RW'(int'(e));
                            drv  = ~fi[0];
                            fi   = fi + 1'b1;
                            done = 1'b1;
                        end
                    end else if (ba) begin
                        e = rom_entry(bp, ROM_COL_W'(bi), MAX_ENTRIES);
                        if (e == MARK_END || e < MARK_REPEAT) begin
                            ba  = 1'b0;
                            drv = 1'b0;
                        end else if (e == MARK_REPEAT) begin
                            drv = 1'b0;
                            bi  = '0;
                        end else begin
                            rem  = (int'(e) > MAX_DURATION) ? RW'(MAX_DURATION) : RW'(int'(e));
                            drv  = ~bi[0];
                            bi   = bi + 1'b1;
                            done = 1'b1;
                        end
                    end else begin
                        rem  = '0;
                        drv  = 1'b0;
                        done = 1'b1;
                    end
                end
            end
            if (!done) begin
                fa  = 1'b0;
                ba  = 1'b0;
                rem = '0;
                drv = 1'b0;
            end
        end

        o_front_active  = fa;
        o_front_pattern = fp;
        o_front_index   = fi;
        o_back_active   = ba;
        o_back_pattern  = bp;
        o_back_index    = bi;
        o_remaining     = rem;
        o_drive         = drv;
        o_result.buzzer_on       = drv;
        o_result.foreground_busy = fa;
        o_result.background_busy = ba;
        o_result.bad_pattern     = bad;
    end

endmodule

@@ rtl/buzzer_pattern_sequencer.sv @@
// Channel   | Direction | Beat        | Handshake
// ----------+-----------+-------------+-----------------------------------
// input     | in        | t_in_item   | i_in_valid / o_in_stall
// result    | out       | t_out_item  | o_out_valid / i_out_stall
//
// One result beat leaves for every input beat; it passes the input register
// and then the result register. A new beat can be accepted in every cycle
// while the result side does not stall; the step logic sits between the two.
// Reset is synchronous and active low; it clears all pattern state.
// The input side stalls only while a beat is held and the result waits stalled.
module buzzer_pattern_sequencer #(
    parameter int PATTERN_COUNT = bps_pkg::DEF_PATTERN_COUNT,
    parameter int MAX_DURATION  = bps_pkg::DEF_MAX_DURATION,
    parameter int MAX_ENTRIES   = bps_pkg::DEF_MAX_ENTRIES
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    input  bps_pkg::t_in_item  i_in_data,
    output logic               o_in_stall,
    output logic               o_out_valid,
    output bps_pkg::t_out_item o_out_data,
    input  logic               i_out_stall
);
    import bps_pkg::*;

    // Index width holds MAX_ENTRIES itself, since the index moves one past
    // the last entry that was loaded. Countdown width holds MAX_DURATION.
    localparam int IW = $clog2(MAX_ENTRIES + 1);
    localparam int RW = $clog2(MAX_DURATION + 1);

    // Input register.
    logic      r_in_valid;
    t_in_item  r_in;

    // Result register.
    logic      r_out_valid;
    t_out_item r_out;

    // Sequencer state.
    logic          r_front_active;
    logic [3:0]    r_front_pattern;
    logic [IW-1:0] r_front_index;
    logic          r_back_active;
    logic [3:0]    r_back_pattern;
    logic [IW-1:0] r_back_index;
    logic [RW-1:0] r_remaining;
    logic          r_drive;

    // Next state from the step logic.
    logic          n_front_active;
    logic [3:0]    n_front_pattern;
    logic [IW-1:0] n_front_index;
    logic          n_back_active;
    logic [3:0]    n_back_pattern;
    logic [IW-1:0] n_back_index;
    logic [RW-1:0] n_remaining;
    logic          n_drive;
    t_out_item     n_out;

    logic advance;

    // The held beat moves on when the result register is free or is being
    // emptied in this cycle. The state is updated only then, so the next
    // beat always sees the state that the previous one left.
    assign advance    = r_in_valid && (!r_out_valid || !i_out_stall);
    assign o_in_stall = r_in_valid && !advance;

    bps_step #(
        .PATTERN_COUNT(PATTERN_COUNT),
        .MAX_DURATION (MAX_DURATION),
        .MAX_ENTRIES  (MAX_ENTRIES),
        .IW           (IW),
        .RW           (RW)
    ) u_step (
        .i_item         (r_in),
        .i_front_active (r_front_active),
        .i_front_pattern(r_front_pattern),
        .i_front_index  (r_front_index),
        .i_back_active  (r_back_active),
        .i_back_pattern (r_back_pattern),
        .i_back_index   (r_back_index),
        .i_remaining    (r_remaining),
        .i_drive        (r_drive),
        .o_front_active (n_front_active),
        .o_front_pattern(n_front_pattern),
        .o_front_index  (n_front_index),
        .o_back_active  (n_back_active),
        .o_back_pattern (n_back_pattern),
        .o_back_index   (n_back_index),
        .o_remaining    (n_remaining),
        .o_drive        (n_drive),
        .o_result       (n_out)
    );

    // Control and sequencer state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid      <= 1'b0;
            r_out_valid     <= 1'b0;
            r_front_active  <= 1'b0;
            r_front_pattern <= '0;
            r_front_index   <= '0;
            r_back_active   <= 1'b0;
            r_back_pattern  <= '0;
            r_back_index    <= '0;
            r_remaining     <= '0;
            r_drive         <= 1'b0;
        end else begin
            if (!o_in_stall) begin
                r_in_valid <= i_in_valid;
            end
            if (advance) begin
                r_out_valid     <= 1'b1;
                r_front_active  <= n_front_active;
                r_front_pattern <= n_front_pattern;
                r_front_index   <= n_front_index;
                r_back_active   <= n_back_active;
                r_back_pattern  <= n_back_pattern;
                r_back_index    <= n_back_index;
                r_remaining     <= n_remaining;
                r_drive         <= n_drive;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload registers carry no reset.
    always_ff @(posedge i_clk) begin
        if (!o_in_stall) begin
            r_in <= i_in_data;
        end
        if (advance) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    // While anything plays or the buzzer sounds, a duration is counting.
    a_busy_counts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_drive || r_front_active || r_back_active) |-> (r_remaining != '0))
        else $error("pattern active with no duration counting");

    // A tick never reports a bad pattern number.
    a_tick_not_bad: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (advance && r_in.operation == OP_TICK) |=> !o_out_data.bad_pattern)
        else $error("bad_pattern set on a tick");

    // The position in a pattern never runs past its usable entries.
    a_index_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (int'(r_front_index) <= MAX_ENTRIES) && (int'(r_back_index) <= MAX_ENTRIES))
        else $error("pattern index out of range");

endmodule

@@ tb/sv/buzzer_pattern_sequencer_test.sv @@
module buzzer_pattern_sequencer_test;

    timeunit 1ns;
    timeprecision 1ps;

    import bps_pkg::*;

    // A result beat leaves only after its input beat is accepted and has passed
    // the input and result registers. The tail wait at the end runs on past the
    // last expected result, so that a stray extra result still gets caught.
    localparam int TAIL_CYCLES    = 8;
    // Cycles in a row with no beat moving on either channel before the run
    // is declared hung. Per-cycle idling at 80 percent never comes close.
    localparam int WATCHDOG_LIMIT = 2000;
    // Input beats that each random phase sends.
    localparam int PHASE_BEATS    = 642;

    // One row of the directed table. When typed is set, exp holds the result
    // (buzzer_on, foreground_busy, background_busy, bad_pattern) as it can be
    // read straight off the behavior; otherwise the beat sequencer model below
    // supplies the expected result.
    typedef struct packed {
        t_op        op;
        logic [3:0] pat;
        logic       typed;
        t_out_item  exp;
    } t_dir_row;

    localparam int DIR_ROWS = 25;
    localparam t_dir_row DIRECTED [DIR_ROWS] = '{
        {OP_TICK,  4'd0,  1'b1, 4'b0000},   // Tick while idle changes nothing.
        {OP_START, 4'd0,  1'b1, 4'b0000},   // Stop while idle.
        {OP_START, 4'd12, 1'b1, 4'b0001},   // Lowest bad pattern number.
        {OP_START, 4'd15, 1'b1, 4'b0001},   // Highest bad pattern number.
        {OP_START, 4'd1,  1'b1, 4'b1100},   // Shortest pattern: 5 ms on.
        {OP_TICK,  4'd15, 1'b0, 4'b0000},
        {OP_TICK,  4'd10, 1'b0, 4'b0000},
        {OP_TICK,  4'd5,  1'b0, 4'b0000},
        {OP_TICK,  4'd0,  1'b0, 4'b0000},
        {OP_TICK,  4'd0,  1'b1, 4'b0000},   // Fifth tick hits the end mark.
        {OP_START, 4'd4,  1'b0, 4'b0000},   // Longest duration in the ROM.
        {OP_START, 4'd7,  1'b0, 4'b0000},   // Command while counting.
        {OP_TICK,  4'd9,  1'b0, 4'b0000},
        {OP_START, 4'd11, 1'b0, 4'b0000},
        {OP_START, 4'd0,  1'b1, 4'b0000},   // Stop while playing.
        {OP_START, 4'd6,  1'b0, 4'b0000},
        {OP_START, 4'd15, 1'b1, 4'b0001},   // Bad number while playing stops.
        {OP_TICK,  4'd3,  1'b1, 4'b0000},
        {OP_START, 4'd8,  1'b0, 4'b0000},
        {OP_START, 4'd9,  1'b0, 4'b0000},
        {OP_START, 4'd10, 1'b0, 4'b0000},
        {OP_START, 4'd5,  1'b0, 4'b0000},
        {OP_START, 4'd2,  1'b0, 4'b0000},
        {OP_START, 4'd3,  1'b0, 4'b0000},
        {OP_START, 4'd13, 1'b1, 4'b0001}
    };

    // Our own copy of the pattern table: on durations sit at even positions,
    // off durations at odd ones, 0 ends a pattern and -1 repeats it.
    int beep_rom [DEF_PATTERN_COUNT][DEF_MAX_ENTRIES] = '{
        '{0,    0,   0,  0,   0,  0,   0},
        '{5,    0,   0,  0,   0,  0,   0},
        '{100,  0,   0,  0,   0,  0,   0},
        '{500,  0,   0,  0,   0,  0,   0},
        '{1000, 0,   0,  0,   0,  0,   0},
        '{80,   160, 80, 680, 0,  0,   0},
        '{80,   160, 80, 680, -1, 0,   0},
        '{80,   50,  80, 50,  80, 600, -1},
        '{500,  160, 80, 160, 80, 0,   0},
        '{80,   50,  80, 50,  80, 0,   0},
        '{80,   50,  80, 0,   0,  0,   0},
        '{150,  50,  80, 0,   0,  0,   0}
    };

    // Signals around the block. Every input starts at a known value.
    logic      clk       = 1'b0;
    logic      rst_n     = 1'b0;
    logic      in_valid  = 1'b0;
    t_in_item  in_beat   = '0;
    logic      in_stall;
    logic      out_valid;
    t_out_item out_beat;
    logic      out_stall = 1'b0;

    // Idling percentages of the current phase.
    int send_gap_pct   = 35;
    int recv_stall_pct = 80;

    // Model state of the sequencer.
    bit front_on;
    int front_pat;
    int front_idx;
    bit back_on;
    int back_pat;
    int back_idx;
    int ms_left;
    bit level;

    t_out_item results_due [$];
    t_out_item due_result;
    int        failures    = 0;
    int        idle_cycles = 0;

    buzzer_pattern_sequencer i_dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .i_in_data   (in_beat),
        .o_in_stall  (in_stall),
        .o_out_valid (out_valid),
        .o_out_data  (out_beat),
        .i_out_stall (out_stall)
    );

    always #5 clk = ~clk;

    // Anything past the usable entries of a pattern reads as an end mark.
    function automatic int rom_duration(input int pat, input int idx);
        if (pat >= DEF_PATTERN_COUNT || idx >= DEF_MAX_ENTRIES) begin
            return int'(MARK_END);
        end
        return beep_rom[pat][idx];
    endfunction

    function automatic void silence_all();
        front_on = 1'b0;
        back_on  = 1'b0;
        ms_left  = 0;
        level    = 1'b0;
    endfunction

    // Loads a duration, capped at the longest allowed, and sets the level
    // from the position: even entries sound, odd entries are quiet.
    function automatic void load_duration(input int dur, input int idx);
        ms_left = (dur > DEF_MAX_DURATION) ? DEF_MAX_DURATION : dur;
        level   = (idx % 2 == 0);
    endfunction

    // Walks through end marks, repeat marks and the handover to the
    // background until a duration is loaded or nothing is left to play.
    // A step that needs too many of these walks stops everything.
    function automatic void settle_pattern();
        int e;
        for (int n = 0; n < RESOLVE_LIMIT; n++) begin
            if (front_on) begin
                e = rom_duration(front_pat, front_idx);
                if (e == int'(MARK_END) || e < int'(MARK_REPEAT)) begin
                    front_on = 1'b0;
                    level    = 1'b0;
                end else if (e == int'(MARK_REPEAT)) begin
                    // The foreground pattern repeats: it moves to the
                    // background and starts over from its first entry.
                    level     = 1'b0;
                    back_on   = 1'b1;
                    back_pat  = front_pat;
                    back_idx  = 0;
                    front_on  = 1'b0;
                end else begin
                    load_duration(e, front_idx);
                    front_idx++;
                    return;
                end
            end else if (back_on) begin
                e = rom_duration(back_pat, back_idx);
                if (e == int'(MARK_END) || e < int'(MARK_REPEAT)) begin
                    back_on = 1'b0;
                    level   = 1'b0;
                end else if (e == int'(MARK_REPEAT)) begin
                    level    = 1'b0;
                    back_idx = 0;
                end else begin
                    load_duration(e, back_idx);
                    back_idx++;
                    return;
                end
            end else begin
                ms_left = 0;
                level   = 1'b0;
                return;
            end
        end
        silence_all();
    endfunction

    // Advances the model by one accepted beat and returns its result.
    function automatic t_out_item step_sequencer(input t_in_item beat);
        t_out_item res;
        bit        bad;
        bad = 1'b0;
        if (beat.operation == OP_START) begin
            bad = (int'(beat.pattern) >= DEF_PATTERN_COUNT);
            if (bad || rom_duration(int'(beat.pattern), 0) == int'(MARK_END)) begin
                silence_all();
            end else begin
                // A new pattern abandons the running duration but keeps
                // whatever is held in the background.
                front_on  = 1'b1;
                front_pat = int'(beat.pattern);
                front_idx = 0;
                ms_left   = 0;
                settle_pattern();
            end
        end else if (ms_left > 0) begin
            ms_left--;
            if (ms_left == 0) begin
                settle_pattern();
            end
        end
        res.buzzer_on       = level;
        res.foreground_busy = front_on;
        res.background_busy = back_on;
        res.bad_pattern     = bad;
        return res;
    endfunction

    // Offers one beat after a random number of idle cycles, waits until it
    // is taken, and files its expected result. A typed result from the
    // directed table takes the place of the model's, which still advances.
    task automatic send_beat(input t_in_item beat, input bit typed, input t_out_item typed_res);
        t_out_item res;
        @(negedge clk);
        while ($urandom_range(0, 99) < send_gap_pct) begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        in_beat  <= beat;
        do begin
            @(posedge clk);
        end while (in_stall);
        res = step_sequencer(beat);
        results_due.push_back(typed ? typed_res : res);
    endtask

    // Holds the input side quiet until every expected result is out.
    task automatic drain_results();
        @(negedge clk);
        in_valid <= 1'b0;
        while (results_due.size() != 0) begin
            @(posedge clk);
        end
    endtask

    // Random stimulus. Most bursts start a well-formed pattern and then tick
    // it for a while; repeating patterns are often ticked all the way through
    // so that a background pattern builds up, which later one-shots overlay.
    // Stop commands and bad numbers, the noise, come in now and then.
    task automatic random_phase(input int beats_wanted);
        t_in_item beat;
        int       sent;
        int       r;
        int       ticks;
        sent = 0;
        while (sent < beats_wanted) begin
            r = $urandom_range(0, 99);
            beat.operation = OP_START;
            if (r < 5) begin
                beat.pattern = 4'd0;
            end else if (r < 10) begin
                beat.pattern = 4'($urandom_range(DEF_PATTERN_COUNT, 15));
            end else if (r < 35) begin
                beat.pattern = $urandom_range(0, 1) ? 4'd6 : 4'd7;
            end else begin
                beat.pattern = 4'($urandom_range(1, DEF_PATTERN_COUNT - 1));
            end
            send_beat(beat, 1'b0, '0);
            sent++;

            r = $urandom_range(0, 99);
            if ((beat.pattern == 4'd6 || beat.pattern == 4'd7) && r < 50) begin
                // The full length of pattern 6 is 1000 ms and of pattern 7
                // 940 ms; a few more ticks carry it into the background.
                ticks = ((beat.pattern == 4'd6) ? 1000 : 940) + $urandom_range(0, 60);
            end else if (r < 55) begin
                ticks = $urandom_range(0, 12);
            end else if (r < 92) begin
                ticks = $urandom_range(12, 220);
            end else begin
                ticks = $urandom_range(300, 1000);
            end
            for (int t = 0; t < ticks && sent < beats_wanted; t++) begin
                beat.operation = OP_TICK;
                beat.pattern   = 4'($urandom_range(0, 15));
                send_beat(beat, 1'b0, '0);
                sent++;
            end
        end
    endtask

    // The receiver stalls at random, decided at each falling edge.
    always @(negedge clk) begin
        out_stall <= ($urandom_range(0, 99) < recv_stall_pct);
    end

    // Result checking and the watchdog. Outputs are sampled at the rising
    // edge, before the block's own updates of that edge take effect.
    always @(posedge clk) begin
        if (rst_n && out_valid && !out_stall) begin
            if (results_due.size() == 0) begin
                $error("result beat with no expectation waiting");
                failures++;
            end else begin
                due_result = results_due.pop_front();
                if (out_beat.buzzer_on !== due_result.buzzer_on) begin
                    $error("buzzer_on: expected %0b, got %0b",
                           due_result.buzzer_on, out_beat.buzzer_on);
                    failures++;
                end
                if (out_beat.foreground_busy !== due_result.foreground_busy) begin
                    $error("foreground_busy: expected %0b, got %0b",
                           due_result.foreground_busy, out_beat.foreground_busy);
                    failures++;
                end
                if (out_beat.background_busy !== due_result.background_busy) begin
                    $error("background_busy: expected %0b, got %0b",
                           due_result.background_busy, out_beat.background_busy);
                    failures++;
                end
                if (out_beat.bad_pattern !== due_result.bad_pattern) begin
                    $error("bad_pattern: expected %0b, got %0b",
                           due_result.bad_pattern, out_beat.bad_pattern);
                    failures++;
                end
            end
        end

        if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
            idle_cycles = 0;
        end else begin
            idle_cycles++;
        end
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    initial begin
        t_in_item beat;
        front_on  = 1'b0;
        front_pat = 0;
        front_idx = 0;
        back_on   = 1'b0;
        back_pat  = 0;
        back_idx  = 0;
        ms_left   = 0;
        level     = 1'b0;

        // Reset is held from time zero and released at a falling edge.
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed part, under the first idling setting.
        for (int r = 0; r < DIR_ROWS; r++) begin
            beat.operation = DIRECTED[r].op;
            beat.pattern   = DIRECTED[r].pat;
            send_beat(beat, DIRECTED[r].typed, DIRECTED[r].exp);
        end
        drain_results();

        // Sender idles less than the receiver stalls.
        random_phase(PHASE_BEATS);
        drain_results();

        // Then the other way round.
        send_gap_pct   = 80;
        recv_stall_pct = 35;
        random_phase(PHASE_BEATS);
        drain_results();

        // Then at full rate on both sides.
        send_gap_pct   = 0;
        recv_stall_pct = 0;
        random_phase(PHASE_BEATS);
        drain_results();

        repeat (TAIL_CYCLES) @(posedge clk);
        if (failures == 0 && results_due.size() == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
